>>> rtl/pia_pkg.sv
// shared constants for the projectile intercept aim pipeline
// no dependencies; imported by the top level
`default_nettype none

package pia_pkg;

  // width of a block-normalized mantissa, sign included
  localparam int NORM_W = 16;
  // bit position of the leading one after block normalization
  localparam int MANT_TOP = 14;
  // top bit of the normalized direction is min(W_TOP_BASE - data width, W_TOP_CAP)
  localparam int W_TOP_BASE = 61;
  localparam int W_TOP_CAP = 29;

endpackage : pia_pkg

`default_nettype wire

>>> rtl/pia_in_if.sv
// valid/ready channel carrying one intercept request
// no dependencies
`default_nettype none

interface pia_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pos_x;
  logic signed [DATA_WIDTH-1:0] pos_y;
  logic signed [DATA_WIDTH-1:0] vel_x;
  logic signed [DATA_WIDTH-1:0] vel_y;
  logic        [DATA_WIDTH-2:0] shot_speed;

  modport source(output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                 output shot_speed, input ready);
  modport sink(input valid, input pos_x, input pos_y, input vel_x, input vel_y,
               input shot_speed, output ready);
endinterface : pia_in_if

`default_nettype wire

>>> rtl/pia_out_if.sv
// valid/ready channel carrying one aim result
// no dependencies
`default_nettype none

interface pia_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] aim_x;
  logic signed [DATA_WIDTH-1:0] aim_y;
  logic                         no_solution;

  modport source(output valid, output aim_x, output aim_y, output no_solution, input ready);
  modport sink(input valid, input aim_x, input aim_y, input no_solution, output ready);
endinterface : pia_out_if

`default_nettype wire

>>> rtl/pia_isqrt_pipe.sv
// pipelined integer square root, one result bit per stage
// no dependencies; side data travels alongside the radicand
`default_nettype none

module pia_isqrt_pipe #(
  parameter int ROOT_W = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [2*ROOT_W-1:0]   in_rad,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic      [ROOT_W-1:0]     out_root,
  output logic      [SIDE_W-1:0]     out_side
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;
  localparam int TRY_W = ROOT_W + 3;

  logic              vld  [ROOT_W];
  logic [RAD_W-1:0]  rad  [ROOT_W];
  logic [REM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [SIDE_W-1:0] side [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_step
    logic              vld_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [SIDE_W-1:0] side_i;
    logic [TRY_W-1:0]  acc;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld[k-1];
      assign rad_i  = rad[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign side_i = side[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign acc   = {rem_i, rad_i[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign fits  = (acc >= trial);
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k]  <= {rad_i[RAD_W-3:0], 2'b00};
        rem[k]  <= fits ? diff[REM_W-1:0] : acc[REM_W-1:0];
        root[k] <= {root_i[ROOT_W-2:0], fits};
        side[k] <= side_i;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule : pia_isqrt_pipe

`default_nettype wire

>>> rtl/pia_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; the numerator's top DEN_W bits must be below the divisor
`default_nettype none

module pia_div_pipe #(
  parameter int QUO_W  = 32,
  parameter int DEN_W  = 31,
  parameter int SIDE_W = 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [QUO_W+DEN_W-1:0]   in_num,
  input  wire logic [DEN_W-1:0]         in_den,
  input  wire logic [SIDE_W-1:0]        in_side,
  output logic                          out_valid,
  output logic      [QUO_W-1:0]         out_quo,
  output logic      [SIDE_W-1:0]        out_side
);

  localparam int NUM_W = QUO_W + DEN_W;

  logic              vld  [QUO_W];
  logic [DEN_W-1:0]  rem  [QUO_W];
  logic [QUO_W-1:0]  nq   [QUO_W];
  logic [DEN_W-1:0]  den  [QUO_W];
  logic [SIDE_W-1:0] side [QUO_W];

  genvar k;
  for (k = 0; k < QUO_W; k++) begin : g_step
    logic              vld_i;
    logic [DEN_W-1:0]  rem_i;
    logic [QUO_W-1:0]  nq_i;
    logic [DEN_W-1:0]  den_i;
    logic [SIDE_W-1:0] side_i;
    logic [DEN_W:0]    acc;
    logic [DEN_W:0]    diff;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = in_num[NUM_W-1:QUO_W];
      assign nq_i   = in_num[QUO_W-1:0];
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld[k-1];
      assign rem_i  = rem[k-1];
      assign nq_i   = nq[k-1];
      assign den_i  = den[k-1];
      assign side_i = side[k-1];
    end

    // numerator bits shift out the top while quotient bits fill the bottom
    assign acc  = {rem_i, nq_i[QUO_W-1]};
    assign fits = (acc >= {1'b0, den_i});
    assign diff = acc - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= fits ? diff[DEN_W-1:0] : acc[DEN_W-1:0];
        nq[k]   <= {nq_i[QUO_W-2:0], fits};
        den[k]  <= den_i;
        side[k] <= side_i;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_quo   = nq[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule : pia_div_pipe

`default_nettype wire

>>> rtl/projectile_intercept_aim.sv
// projectile intercept aim: lead-angle solver as one long pipeline
// depends on pia_pkg, pia_in_if, pia_out_if, pia_isqrt_pipe, pia_div_pipe
`default_nettype none

//  channel   dir   payload                                       role
//  target    in    pos_x pos_y vel_x vel_y shot_speed            relative target state, speed
//  aim       out   aim_x aim_y no_solution                       aim velocity or no-solution
//
//  one transfer in and one out per cycle sustained while the output is accepted;
//  the latency lies mostly in the
//  32-step discriminant square root, the (WTOP+2)-step length square root
//  and the DATA_WIDTH-step divide for the aim components.
//  reset clears only the stage valid bits; data registers are not reset.
//  the whole pipeline holds while a result waits at the output register.

module projectile_intercept_aim
  import pia_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  pia_in_if.sink    target,
  pia_out_if.source aim
);

  localparam int DW      = DATA_WIDTH;
  localparam int HW      = $clog2(DW);
  localparam int NW      = NORM_W;
  localparam int PW      = 2 * NW;
  localparam int ABC_W   = PW + 1;
  localparam int D_W     = 2 * ABC_W + 1;
  localparam int ROOT1_W = PW;
  localparam int RAD1_W  = 2 * ROOT1_W;
  localparam int U_W     = ABC_W + 1;
  localparam int XA_W    = NW + ABC_W;
  localparam int XU_W    = NW + U_W;
  localparam int W_W     = XU_W + 1;
  localparam int HWW     = $clog2(W_W);
  localparam int WTOP    = (W_TOP_BASE - DW < W_TOP_CAP) ? (W_TOP_BASE - DW) : W_TOP_CAP;
  localparam int WN_W    = WTOP + 1;
  localparam int SQ_W    = 2 * WN_W;
  localparam int ROOT2_W = WTOP + 2;
  localparam int RAD2_W  = 2 * ROOT2_W;
  localparam int NUM_W   = (DW - 1) + WN_W;
  localparam int SIDE1_W = 1 + 2 * ABC_W + 4 * NW + (DW - 1);
  localparam int SIDE2_W = 3 + 2 * NUM_W;

  // ---------------------------------------------------------------- helpers

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] x);
    logic [DW-1:0] ux;
    ux = x;
    return x[DW-1] ? (~ux + DW'(1)) : ux;
  endfunction

  function automatic logic [W_W-1:0] mag_w(input logic signed [W_W-1:0] x);
    logic [W_W-1:0] ux;
    ux = x;
    return x[W_W-1] ? (~ux + W_W'(1)) : ux;
  endfunction

  // position of the leading one (zero for zero)
  function automatic logic [HW-1:0] msb_d(input logic [DW-1:0] m);
    logic [HW-1:0] idx;
    idx = '0;
    for (int i = 0; i < DW; i++) begin
      if (m[i]) idx = HW'(i);
    end
    return idx;
  endfunction

  function automatic logic [HWW-1:0] msb_w(input logic [W_W-1:0] m);
    logic [HWW-1:0] idx;
    idx = '0;
    for (int i = 0; i < W_W; i++) begin
      if (m[i]) idx = HWW'(i);
    end
    return idx;
  endfunction

  // block shift so that the leading one lands on MANT_TOP, truncating
  function automatic logic [NW-2:0] norm_d(input logic [DW-1:0] m, input logic [HW-1:0] h);
    logic [DW-1:0] t;
    if (h > HW'(MANT_TOP)) t = m >> (h - HW'(MANT_TOP));
    else                   t = m << (HW'(MANT_TOP) - h);
    return t[NW-2:0];
  endfunction

  function automatic logic [WN_W-1:0] norm_w(input logic [W_W-1:0] m, input logic [HWW-1:0] h);
    logic [W_W-1:0] t;
    if (h > HWW'(WTOP)) t = m >> (h - HWW'(WTOP));
    else                t = m << (HWW'(WTOP) - h);
    return t[WN_W-1:0];
  endfunction

  function automatic logic signed [NW-1:0] apply_sign(input logic neg, input logic [NW-2:0] m);
    logic signed [NW-1:0] v;
    v = signed'({1'b0, m});
    return neg ? -v : v;
  endfunction

  // ------------------------------------------------------------ flow control
  // one enable for every stage: advance unless the output holds a result that is not taken

  logic en;
  logic r18_vld;

  assign en           = !r18_vld || aim.ready;
  assign target.ready = en;

  // stage 1: input capture
  logic                 r1_vld;
  logic signed [DW-1:0] r1_px, r1_py, r1_vx, r1_vy;
  logic        [DW-2:0] r1_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
    end else if (en) begin
      r1_vld <= target.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_px  <= target.pos_x;
      r1_py  <= target.pos_y;
      r1_vx  <= target.vel_x;
      r1_vy  <= target.vel_y;
      r1_spd <= target.shot_speed;
    end
  end

  // stage 2: magnitudes and signs
  logic          r2_vld;
  logic [DW-1:0] r2_mpx, r2_mpy, r2_mvx, r2_mvy, r2_ms;
  logic [3:0]    r2_ng;
  logic [DW-2:0] r2_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_vld <= 1'b0;
    end else if (en) begin
      r2_vld <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_mpx <= mag_d(r1_px);
      r2_mpy <= mag_d(r1_py);
      r2_mvx <= mag_d(r1_vx);
      r2_mvy <= mag_d(r1_vy);
      r2_ms  <= {1'b0, r1_spd};
      r2_ng  <= {r1_vy[DW-1], r1_vx[DW-1], r1_py[DW-1], r1_px[DW-1]};
      r2_spd <= r1_spd;
    end
  end

  // stage 3: block maxima for position and for (velocity, speed)
  logic          r3_vld;
  logic [DW-1:0] r3_mpx, r3_mpy, r3_mvx, r3_mvy, r3_ms, r3_mp, r3_mv;
  logic [3:0]    r3_ng;
  logic [DW-2:0] r3_spd;
  logic [DW-1:0] mv_vel;

  assign mv_vel = (r2_mvx > r2_mvy) ? r2_mvx : r2_mvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_vld <= 1'b0;
    end else if (en) begin
      r3_vld <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_mpx <= r2_mpx;
      r3_mpy <= r2_mpy;
      r3_mvx <= r2_mvx;
      r3_mvy <= r2_mvy;
      r3_ms  <= r2_ms;
      r3_mp  <= (r2_mpx > r2_mpy) ? r2_mpx : r2_mpy;
      r3_mv  <= (r2_ms > mv_vel) ? r2_ms : mv_vel;
      r3_ng  <= r2_ng;
      r3_spd <= r2_spd;
    end
  end

  // stage 4: leading-one positions; zero position, or zero velocity with zero speed, has no answer
  logic          r4_vld, r4_bad;
  logic [DW-1:0] r4_mpx, r4_mpy, r4_mvx, r4_mvy, r4_ms;
  logic [HW-1:0] r4_hp, r4_hv;
  logic [3:0]    r4_ng;
  logic [DW-2:0] r4_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r4_vld <= 1'b0;
    end else if (en) begin
      r4_vld <= r3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_mpx <= r3_mpx;
      r4_mpy <= r3_mpy;
      r4_mvx <= r3_mvx;
      r4_mvy <= r3_mvy;
      r4_ms  <= r3_ms;
      r4_hp  <= msb_d(r3_mp);
      r4_hv  <= msb_d(r3_mv);
      r4_bad <= (r3_mp == '0) || (r3_mv == '0);
      r4_ng  <= r3_ng;
      r4_spd <= r3_spd;
    end
  end

  // stage 5: block-normalized mantissas
  logic                 r5_vld, r5_bad;
  logic signed [NW-1:0] r5_npx, r5_npy, r5_nvx, r5_nvy, r5_ns;
  logic        [DW-2:0] r5_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r5_vld <= 1'b0;
    end else if (en) begin
      r5_vld <= r4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_npx <= apply_sign(r4_ng[0], norm_d(r4_mpx, r4_hp));
      r5_npy <= apply_sign(r4_ng[1], norm_d(r4_mpy, r4_hp));
      r5_nvx <= apply_sign(r4_ng[2], norm_d(r4_mvx, r4_hv));
      r5_nvy <= apply_sign(r4_ng[3], norm_d(r4_mvy, r4_hv));
      r5_ns  <= apply_sign(1'b0, norm_d(r4_ms, r4_hv));
      r5_bad <= r4_bad;
      r5_spd <= r4_spd;
    end
  end

  // stage 6: all mantissa products
  logic                 r6_vld, r6_bad;
  logic signed [PW-1:0] r6_ss, r6_vxx, r6_vyy, r6_bxp, r6_byp, r6_cxx, r6_cyy;
  logic signed [NW-1:0] r6_npx, r6_npy, r6_nvx, r6_nvy;
  logic        [DW-2:0] r6_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r6_vld <= 1'b0;
    end else if (en) begin
      r6_vld <= r5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r6_ss  <= r5_ns * r5_ns;
      r6_vxx <= r5_nvx * r5_nvx;
      r6_vyy <= r5_nvy * r5_nvy;
      r6_bxp <= r5_nvx * r5_npx;
      r6_byp <= r5_nvy * r5_npy;
      r6_cxx <= r5_npx * r5_npx;
      r6_cyy <= r5_npy * r5_npy;
      r6_npx <= r5_npx;
      r6_npy <= r5_npy;
      r6_nvx <= r5_nvx;
      r6_nvy <= r5_nvy;
      r6_bad <= r5_bad;
      r6_spd <= r5_spd;
    end
  end

  // stage 7: quadratic coefficients a = s^2 - v.v, b = v.p, c = p.p
  logic                    r7_vld, r7_bad;
  logic signed [ABC_W-1:0] r7_a, r7_b, r7_c;
  logic signed [NW-1:0]    r7_npx, r7_npy, r7_nvx, r7_nvy;
  logic        [DW-2:0]    r7_spd;
  logic signed [ABC_W-1:0] a_next;

  assign a_next = ABC_W'(r6_ss) - ABC_W'(r6_vxx) - ABC_W'(r6_vyy);

  always_ff @(posedge clk) begin
    if (rst) begin
      r7_vld <= 1'b0;
    end else if (en) begin
      r7_vld <= r6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r7_a   <= a_next;
      r7_b   <= ABC_W'(r6_bxp) + ABC_W'(r6_byp);
      r7_c   <= ABC_W'(r6_cxx) + ABC_W'(r6_cyy);
      r7_npx <= r6_npx;
      r7_npy <= r6_npy;
      r7_nvx <= r6_nvx;
      r7_nvy <= r6_nvy;
      r7_bad <= r6_bad || (a_next == '0);
      r7_spd <= r6_spd;
    end
  end

  // stage 8: discriminant products
  logic                      r8_vld, r8_bad;
  logic signed [2*ABC_W-1:0] r8_bb, r8_ac;
  logic signed [ABC_W-1:0]   r8_a, r8_b;
  logic signed [NW-1:0]      r8_npx, r8_npy, r8_nvx, r8_nvy;
  logic        [DW-2:0]      r8_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r8_vld <= 1'b0;
    end else if (en) begin
      r8_vld <= r7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r8_bb  <= r7_b * r7_b;
      r8_ac  <= r7_a * r7_c;
      r8_a   <= r7_a;
      r8_b   <= r7_b;
      r8_npx <= r7_npx;
      r8_npy <= r7_npy;
      r8_nvx <= r7_nvx;
      r8_nvy <= r7_nvy;
      r8_bad <= r7_bad;
      r8_spd <= r7_spd;
    end
  end

  // stage 9: discriminant d = b^2 + a c; a negative one has no intercept
  logic                    r9_vld, r9_bad;
  logic        [RAD1_W-1:0] r9_rad;
  logic signed [ABC_W-1:0] r9_a, r9_b;
  logic signed [NW-1:0]    r9_npx, r9_npy, r9_nvx, r9_nvy;
  logic        [DW-2:0]    r9_spd;
  logic signed [D_W-1:0]   d_full;
  logic                    d_neg;

  assign d_full = D_W'(r8_bb) + D_W'(r8_ac);
  assign d_neg  = d_full[D_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      r9_vld <= 1'b0;
    end else if (en) begin
      r9_vld <= r8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r9_rad <= d_neg ? '0 : d_full[RAD1_W-1:0];
      r9_a   <= r8_a;
      r9_b   <= r8_b;
      r9_npx <= r8_npx;
      r9_npy <= r8_npy;
      r9_nvx <= r8_nvx;
      r9_nvy <= r8_nvy;
      r9_bad <= r8_bad || d_neg;
      r9_spd <= r8_spd;
    end
  end

  // discriminant root, ROOT1_W stages
  logic               sq1_vld;
  logic [ROOT1_W-1:0] sq1_root;
  logic [SIDE1_W-1:0] sq1_side_in, sq1_side;

  assign sq1_side_in = {r9_bad, r9_a, r9_b, r9_npx, r9_npy, r9_nvx, r9_nvy, r9_spd};

  pia_isqrt_pipe #(
    .ROOT_W(ROOT1_W),
    .SIDE_W(SIDE1_W)
  ) u_sqrt_disc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r9_vld),
    .in_rad   (r9_rad),
    .in_side  (sq1_side_in),
    .out_valid(sq1_vld),
    .out_root (sq1_root),
    .out_side (sq1_side)
  );

  logic                    s1_bad;
  logic signed [ABC_W-1:0] s1_a, s1_b;
  logic signed [NW-1:0]    s1_npx, s1_npy, s1_nvx, s1_nvy;
  logic        [DW-2:0]    s1_spd;

  assign {s1_bad, s1_a, s1_b, s1_npx, s1_npy, s1_nvx, s1_nvy, s1_spd} = sq1_side;

  // stage 10: u = b + sqrt(d)
  logic                    r10_vld, r10_bad;
  logic signed [U_W-1:0]   r10_u;
  logic signed [ABC_W-1:0] r10_a;
  logic signed [NW-1:0]    r10_npx, r10_npy, r10_nvx, r10_nvy;
  logic        [DW-2:0]    r10_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r10_vld <= 1'b0;
    end else if (en) begin
      r10_vld <= sq1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r10_u   <= U_W'(s1_b) + signed'(U_W'(sq1_root));
      r10_a   <= s1_a;
      r10_npx <= s1_npx;
      r10_npy <= s1_npy;
      r10_nvx <= s1_nvx;
      r10_nvy <= s1_nvy;
      r10_bad <= s1_bad;
      r10_spd <= s1_spd;
    end
  end

  // stage 11: direction products p*a and v*u
  logic                   r11_vld, r11_bad, r11_aneg;
  logic signed [XA_W-1:0] r11_xa, r11_ya;
  logic signed [XU_W-1:0] r11_xu, r11_yu;
  logic        [DW-2:0]   r11_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r11_vld <= 1'b0;
    end else if (en) begin
      r11_vld <= r10_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r11_xa   <= r10_npx * r10_a;
      r11_ya   <= r10_npy * r10_a;
      r11_xu   <= r10_nvx * r10_u;
      r11_yu   <= r10_nvy * r10_u;
      r11_aneg <= r10_a[ABC_W-1];
      r11_bad  <= r10_bad;
      r11_spd  <= r10_spd;
    end
  end

  // stage 12: intercept direction before the sign of a is applied
  logic                  r12_vld, r12_bad, r12_aneg;
  logic signed [W_W-1:0] r12_wx, r12_wy;
  logic        [DW-2:0]  r12_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r12_vld <= 1'b0;
    end else if (en) begin
      r12_vld <= r11_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r12_wx   <= W_W'(r11_xa) + W_W'(r11_xu);
      r12_wy   <= W_W'(r11_ya) + W_W'(r11_yu);
      r12_aneg <= r11_aneg;
      r12_bad  <= r11_bad;
      r12_spd  <= r11_spd;
    end
  end

  // stage 13: direction magnitudes; a negative a flips both signs
  logic           r13_vld, r13_bad, r13_sx, r13_sy;
  logic [W_W-1:0] r13_mx, r13_my, r13_mw;
  logic [DW-2:0]  r13_spd;
  logic [W_W-1:0] mwx, mwy;

  assign mwx = mag_w(r12_wx);
  assign mwy = mag_w(r12_wy);

  always_ff @(posedge clk) begin
    if (rst) begin
      r13_vld <= 1'b0;
    end else if (en) begin
      r13_vld <= r12_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r13_mx  <= mwx;
      r13_my  <= mwy;
      r13_mw  <= (mwx > mwy) ? mwx : mwy;
      r13_sx  <= r12_wx[W_W-1] ^ r12_aneg;
      r13_sy  <= r12_wy[W_W-1] ^ r12_aneg;
      r13_bad <= r12_bad;
      r13_spd <= r12_spd;
    end
  end

  // stage 14: leading one of the direction; a zero direction has no answer
  logic           r14_vld, r14_bad, r14_sx, r14_sy;
  logic [W_W-1:0] r14_mx, r14_my;
  logic [HWW-1:0] r14_hw;
  logic [DW-2:0]  r14_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r14_vld <= 1'b0;
    end else if (en) begin
      r14_vld <= r13_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r14_mx  <= r13_mx;
      r14_my  <= r13_my;
      r14_hw  <= msb_w(r13_mw);
      r14_sx  <= r13_sx;
      r14_sy  <= r13_sy;
      r14_bad <= r13_bad || (r13_mw == '0);
      r14_spd <= r13_spd;
    end
  end

  // stage 15: direction normalized to leading one at WTOP
  logic            r15_vld, r15_bad, r15_sx, r15_sy;
  logic [WN_W-1:0] r15_mx, r15_my;
  logic [DW-2:0]   r15_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r15_vld <= 1'b0;
    end else if (en) begin
      r15_vld <= r14_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r15_mx  <= norm_w(r14_mx, r14_hw);
      r15_my  <= norm_w(r14_my, r14_hw);
      r15_sx  <= r14_sx;
      r15_sy  <= r14_sy;
      r15_bad <= r14_bad;
      r15_spd <= r14_spd;
    end
  end

  // stage 16: squares for the length and speed-scaled numerators
  logic             r16_vld, r16_bad, r16_sx, r16_sy;
  logic [SQ_W-1:0]  r16_xx, r16_yy;
  logic [NUM_W-1:0] r16_nx, r16_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      r16_vld <= 1'b0;
    end else if (en) begin
      r16_vld <= r15_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r16_xx  <= r15_mx * r15_mx;
      r16_yy  <= r15_my * r15_my;
      r16_nx  <= r15_spd * r15_mx;
      r16_ny  <= r15_spd * r15_my;
      r16_sx  <= r15_sx;
      r16_sy  <= r15_sy;
      r16_bad <= r15_bad;
    end
  end

  // stage 17: squared length
  logic              r17_vld;
  logic [RAD2_W-1:0] r17_rad;
  logic [SIDE2_W-1:0] r17_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      r17_vld <= 1'b0;
    end else if (en) begin
      r17_vld <= r16_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r17_rad  <= RAD2_W'(r16_xx) + RAD2_W'(r16_yy);
      r17_side <= {r16_bad, r16_sx, r16_sy, r16_nx, r16_ny};
    end
  end

  // length root, ROOT2_W stages
  logic               sq2_vld;
  logic [ROOT2_W-1:0] sq2_root;
  logic [SIDE2_W-1:0] sq2_side;

  pia_isqrt_pipe #(
    .ROOT_W(ROOT2_W),
    .SIDE_W(SIDE2_W)
  ) u_sqrt_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r17_vld),
    .in_rad   (r17_rad),
    .in_side  (r17_side),
    .out_valid(sq2_vld),
    .out_root (sq2_root),
    .out_side (sq2_side)
  );

  logic             s2_bad, s2_sx, s2_sy;
  logic [NUM_W-1:0] s2_nx, s2_ny;
  logic [1:0]       divx_side_in, divx_side;
  logic             divx_vld, divy_vld, divy_side;
  logic [DW-1:0]    qx, qy;

  assign {s2_bad, s2_sx, s2_sy, s2_nx, s2_ny} = sq2_side;
  assign divx_side_in = {s2_bad || (sq2_root == '0), s2_sx};

  // aim magnitudes s*|w|/len, DW stages each
  pia_div_pipe #(
    .QUO_W (DW),
    .DEN_W (ROOT2_W),
    .SIDE_W(2)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq2_vld),
    .in_num   ({2'b00, s2_nx}),
    .in_den   (sq2_root),
    .in_side  (divx_side_in),
    .out_valid(divx_vld),
    .out_quo  (qx),
    .out_side (divx_side)
  );

  pia_div_pipe #(
    .QUO_W (DW),
    .DEN_W (ROOT2_W),
    .SIDE_W(1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq2_vld),
    .in_num   ({2'b00, s2_ny}),
    .in_den   (sq2_root),
    .in_side  (s2_sy),
    .out_valid(divy_vld),
    .out_quo  (qy),
    .out_side (divy_side)
  );

  // stage 18: sign, saturation and the output register
  logic signed [DW-1:0] r18_ax, r18_ay;
  logic                 r18_bad;
  logic signed [DW-1:0] ax_next, ay_next;

  function automatic logic signed [DW-1:0] sat_signed(input logic neg, input logic [DW-1:0] q);
    logic [DW-1:0] r;
    if (neg) r = q[DW-1] ? {1'b1, {(DW-1){1'b0}}} : (~q + DW'(1));
    else     r = q[DW-1] ? {1'b0, {(DW-1){1'b1}}} : q;
    return signed'(r);
  endfunction

  assign ax_next = divx_side[1] ? '0 : sat_signed(divx_side[0], qx);
  assign ay_next = divx_side[1] ? '0 : sat_signed(divy_side, qy);

  always_ff @(posedge clk) begin
    if (rst) begin
      r18_vld <= 1'b0;
    end else if (en) begin
      r18_vld <= divx_vld && divy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r18_ax  <= ax_next;
      r18_ay  <= ay_next;
      r18_bad <= divx_side[1];
    end
  end

  assign aim.valid       = r18_vld;
  assign aim.aim_x       = r18_ax;
  assign aim.aim_y       = r18_ay;
  assign aim.no_solution = r18_bad;

endmodule : projectile_intercept_aim

`default_nettype wire
